FILE: rtl/core/fic_pkg.sv
// Shared types and constants for the Fenwick inversion counter.
package fic_pkg;

	localparam int VALUE_W     = 10;
	localparam int CNT_W       = 11;
	localparam int TOTAL_W     = 20;
	localparam int OUT_TOTAL_W = 19;
	localparam int ADDED_W     = 10;
	localparam int LEN_W       = 11;

	localparam logic [LEN_W-1:0]       SEQ_LEN_RESET = 11'd1024;
	localparam logic [TOTAL_W-1:0]     TOTAL_MAX     = '1;
	localparam logic [OUT_TOTAL_W-1:0] OUT_TOTAL_MAX = '1;
	localparam logic [ADDED_W-1:0]     ADDED_MAX     = '1;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               first_item;
	} fic_item_t;

	typedef struct packed {
		logic [ADDED_W-1:0]     added_inversions;
		logic [OUT_TOTAL_W-1:0] total_inversions;
		logic                   bad_value;
	} fic_result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_PFX,
		ST_PDRAIN,
		ST_RESULT,
		ST_UPD,
		ST_UDRAIN
	} fic_state_t;

	typedef struct packed {
		logic take;
		logic seq_clr;
		logic x_zero;
		logic x_inc;
		logic clr_wr;
		logic x_load_v;
		logic pfx_rd;
		logic upd_rd;
		logic result;
	} fic_cmd_t;

	typedef struct packed {
		logic accept;
		logic first;
		logic bad;
		logic clr_done;
		logic pfx_last;
		logic upd_last;
		logic out_free;
	} fic_status_t;

endpackage

FILE: rtl/core/fic_stream_if.sv
// Valid/ready stream interface with a typed payload.
interface fic_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/fic_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fic_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: rtl/core/fic_ctrl.sv
// Controller state machine that sequences clears, prefix walks and update walks.
module fic_ctrl import fic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  fic_status_t st,
	output fic_cmd_t    cmd
);
	fic_state_t state_q, state_d;
	logic       pend_q, pend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				cmd.x_inc  = 1'b1;
				if (st.clr_done) begin
					state_d = pend_q ? ST_CHECK : ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.take = 1'b1;
				if (st.accept) begin
					if (st.first) begin
						// A new sequence wipes the tree before this item is handled.
						cmd.seq_clr = 1'b1;
						cmd.x_zero  = 1'b1;
						pend_d      = 1'b1;
						state_d     = ST_CLEAR;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				pend_d = 1'b0;
				if (st.bad) begin
					state_d = ST_RESULT;
				end else begin
					cmd.x_load_v = 1'b1;
					state_d      = ST_PFX;
				end
			end
			ST_PFX: begin
				cmd.pfx_rd = 1'b1;
				if (st.pfx_last) begin
					state_d = ST_PDRAIN;
				end
			end
			ST_PDRAIN: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (st.out_free) begin
					cmd.result = 1'b1;
					if (st.bad) begin
						state_d = ST_IDLE;
					end else begin
						cmd.x_load_v = 1'b1;
						state_d      = ST_UPD;
					end
				end
			end
			ST_UPD: begin
				cmd.upd_rd = 1'b1;
				if (st.upd_last) begin
					state_d = ST_UDRAIN;
				end
			end
			ST_UDRAIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

FILE: rtl/core/fic_datapath.sv
// Datapath: tree memory, walk index, accumulators, totals and output register.
module fic_datapath import fic_pkg::*; #(
	parameter int MAX_LEN = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LEN_W-1:0]   cfg_wdata,
	input  fic_cmd_t           cmd,
	output fic_status_t        st,
	fic_stream_if.sink         items,
	fic_stream_if.source       results
);
	localparam int AW    = $clog2(MAX_LEN);
	localparam int CMP_W = (AW + 1 > VALUE_W) ? AW + 1 : VALUE_W;
	localparam logic [AW:0]   LEN_X  = (AW + 1)'(MAX_LEN);
	localparam logic [AW-1:0] LAST_X = AW'(MAX_LEN - 1);

	logic [LEN_W-1:0]   seq_len_q;
	logic [VALUE_W-1:0] v_q;
	logic [AW-1:0]      x_q;
	logic [CNT_W-1:0]   acc_q;
	logic [CNT_W-1:0]   items_q;
	logic [TOTAL_W-1:0] total_q;
	logic               acc_s1;
	logic               inc_s1;
	logic [AW-1:0]      addr_s1;
	logic               out_valid_q;
	fic_result_t        out_q;

	logic [CNT_W-1:0]   rdata;
	logic [AW:0]        x_ext, x_p1, pfx_base, upd_next;
	logic               bad;
	logic [CNT_W-1:0]   greater;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] tot_new, tot_res;
	fic_result_t        res_d;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [CNT_W-1:0]   ram_wdata;

	assign x_ext    = {1'b0, x_q};
	assign x_p1     = x_ext + (AW + 1)'(1);
	assign pfx_base = x_ext & x_p1;
	assign upd_next = x_ext | x_p1;

	assign bad = (LEN_W'(v_q) >= seq_len_q) || (CMP_W'(v_q) >= CMP_W'(MAX_LEN));

	// Earlier items minus those at or below the value, modulo the counter width.
	assign greater = items_q - acc_q;
	assign sum     = {1'b0, total_q} + (TOTAL_W + 1)'(greater);
	assign tot_new = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
	assign tot_res = bad ? total_q : tot_new;

	always_comb begin
		res_d.bad_value = bad;
		if (bad) begin
			res_d.added_inversions = '0;
		end else if (greater > CNT_W'(ADDED_MAX)) begin
			res_d.added_inversions = ADDED_MAX;
		end else begin
			res_d.added_inversions = greater[ADDED_W-1:0];
		end
		if (tot_res > TOTAL_W'(OUT_TOTAL_MAX)) begin
			res_d.total_inversions = OUT_TOTAL_MAX;
		end else begin
			res_d.total_inversions = tot_res[OUT_TOTAL_W-1:0];
		end
	end

	assign st.accept   = items.valid && cmd.take;
	assign st.first    = items.data.first_item;
	assign st.bad      = bad;
	assign st.clr_done = (x_q == LAST_X);
	assign st.pfx_last = (pfx_base == '0);
	assign st.upd_last = (upd_next >= LEN_X);
	assign st.out_free = !out_valid_q || results.ready;

	assign items.ready   = cmd.take;
	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	// The update walk writes back each node in the cycle after it is read, while reading the next one.
	assign ram_we    = cmd.clr_wr || inc_s1;
	assign ram_waddr = inc_s1 ? addr_s1 : x_q;
	assign ram_wdata = inc_s1 ? (rdata + CNT_W'(1)) : '0;

	fic_ram #(
		.WIDTH (CNT_W),
		.DEPTH (MAX_LEN)
	) u_tree (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (x_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q   <= SEQ_LEN_RESET;
			x_q         <= '0;
			acc_q       <= '0;
			items_q     <= '0;
			total_q     <= '0;
			acc_s1      <= 1'b0;
			inc_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seq_len_q <= cfg_wdata;
			end

			priority if (cmd.x_zero) begin
				x_q <= '0;
			end else if (cmd.x_inc) begin
				x_q <= x_p1[AW-1:0];
			end else if (cmd.x_load_v) begin
				x_q <= AW'(v_q);
			end else if (cmd.pfx_rd) begin
				x_q <= AW'(pfx_base - (AW + 1)'(1));
			end else if (cmd.upd_rd) begin
				x_q <= upd_next[AW-1:0];
			end

			if (cmd.x_load_v) begin
				acc_q <= '0;
			end else if (acc_s1) begin
				acc_q <= acc_q + rdata;
			end

			acc_s1 <= cmd.pfx_rd;
			inc_s1 <= cmd.upd_rd;

			if (cmd.seq_clr) begin
				items_q <= '0;
				total_q <= '0;
			end else if (cmd.result && !bad) begin
				items_q <= items_q + CNT_W'(1);
				total_q <= tot_new;
			end

			if (cmd.result) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st.accept) begin
			v_q <= items.data.value;
		end
		addr_s1 <= x_q;
		if (cmd.result) begin
			out_q <= res_d;
		end
	end
endmodule

FILE: rtl/core/fenwick_inversion_counter_top.sv
// A result is registered after the prefix walk, or straight after the range check for an
// out-of-range value; a stalled receiver holds the block at its next result until it takes the last.
// The block takes one item at a time, the next one only after the update walk (or after the
// result of an out-of-range value); the walks visit one node per cycle over the tree memory.
// A first_item clear sweeps the tree first; the same sweep runs after reset before the first
// item is taken, with seq_length at 1024 and counts and total at zero.
module fenwick_inversion_counter_top import fic_pkg::*; #(
	parameter int MAX_LEN = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	fic_stream_if.sink       items,
	fic_stream_if.source     results
);
	fic_cmd_t    cmd;
	fic_status_t st;

	fic_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	fic_datapath #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.st        (st),
		.items     (items),
		.results   (results)
	);
endmodule

FILE: rtl/core/fic_checker.sv
// Port-level checker for the inversion counter and its bind to the top level.
module fic_checker import fic_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        items_valid,
	input logic        items_ready,
	input logic        results_valid,
	input logic        results_ready,
	input fic_result_t results_data
);
	// The block works on one item at a time, so a transfer drops ready right after it.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		items_valid && items_ready |=> !items_ready)
		else $error("input ready stayed high after a transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		results_valid && !results_ready |=> results_valid && $stable(results_data))
		else $error("stalled result changed or vanished");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results_valid && results_data.bad_value |-> results_data.added_inversions == '0)
		else $error("ignored value reported inversions");

	a_total_covers: assert property (@(posedge clk) disable iff (!arst_n)
		results_valid && !results_data.bad_value |->
		results_data.total_inversions >= OUT_TOTAL_W'(results_data.added_inversions))
		else $error("running total below the count just added");
endmodule

bind fenwick_inversion_counter_top fic_checker u_fic_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.items_valid   (items.valid),
	.items_ready   (items.ready),
	.results_valid (results.valid),
	.results_ready (results.ready),
	.results_data  (results.data)
);

FILE: tb/sv/fic_inversion_checker.sv
// Checker for the inversion counter: follows both streams, predicts each result and compares.
module fic_inversion_checker import fic_pkg::*; #(
	parameter int MAX_LEN = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	input  logic             item_valid,
	input  logic             item_ready,
	input  fic_item_t        item_data,
	input  logic             result_valid,
	input  logic             result_ready,
	input  fic_result_t      result_data,
	output int               n_fail,
	output int               n_pending,
	output int               n_checked,
	output int               n_bad
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CNT_W-1:0]   node_cnt [MAX_LEN];
	logic [CNT_W-1:0]   seen_cnt;
	logic [TOTAL_W-1:0] seq_total;
	logic [LEN_W-1:0]   len_reg;
	fic_result_t        pending_results [$];
	int                 fails;
	int                 checked;
	int                 bad_seen;

	task automatic clear_counts();
		foreach (node_cnt[k]) node_cnt[k] = '0;
		seen_cnt = '0;
		seq_total = '0;
	endtask

	// Updates the tree and totals for one item and returns the result it must produce.
	task automatic predict_inversions(input fic_item_t it, output fic_result_t res);
		int                 lim;
		int                 i;
		int                 j;
		logic [CNT_W-1:0]   le_cnt;
		logic [CNT_W-1:0]   greater;
		logic [TOTAL_W:0]   sum;
		lim = (int'(len_reg) < MAX_LEN) ? int'(len_reg) : MAX_LEN;
		if (it.first_item) begin
			clear_counts();
		end
		res = '0;
		if (int'(it.value) >= lim) begin
			res.bad_value = 1'b1;
		end else begin
			le_cnt = '0;
			// Prefix walk: strip the lowest set bit of the one-based index each step.
			for (i = int'(it.value) + 1; i > 0; i = i & (i - 1)) begin
				le_cnt = le_cnt + node_cnt[i-1];
			end
			greater = seen_cnt - le_cnt;
			sum = {1'b0, seq_total} + (TOTAL_W + 1)'(greater);
			seq_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
			// The update always walks up to the tree size, independent of the length setting.
			for (j = int'(it.value); j < MAX_LEN; j = j | (j + 1)) begin
				node_cnt[j] = node_cnt[j] + CNT_W'(1);
			end
			seen_cnt = seen_cnt + CNT_W'(1);
			res.added_inversions = (greater > ADDED_MAX) ? ADDED_MAX : greater[ADDED_W-1:0];
		end
		res.total_inversions = (seq_total > OUT_TOTAL_MAX) ? OUT_TOTAL_MAX
			: seq_total[OUT_TOTAL_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		fic_result_t want;
		if (!arst_n) begin
			clear_counts();
			len_reg = SEQ_LEN_RESET;
			pending_results.delete();
			fails = 0;
			checked = 0;
			bad_seen = 0;
			n_fail <= 0;
			n_pending <= 0;
			n_checked <= 0;
			n_bad <= 0;
		end else begin
			if (cfg_we) begin
				len_reg = cfg_wdata;
			end
			// Results trail their items, so the pop precedes the append.
			if (result_valid && result_ready) begin
				if (pending_results.size() == 0) begin
					$error("result transfer with no item outstanding: added %0d total %0d bad %0d",
						result_data.added_inversions, result_data.total_inversions,
						result_data.bad_value);
					fails++;
				end else begin
					want = pending_results.pop_front();
					checked++;
					if (want.bad_value) bad_seen++;
					if (result_data.added_inversions !== want.added_inversions) begin
						$error("added_inversions: expected %0d, actual %0d",
							want.added_inversions, result_data.added_inversions);
						fails++;
					end
					if (result_data.total_inversions !== want.total_inversions) begin
						$error("total_inversions: expected %0d, actual %0d",
							want.total_inversions, result_data.total_inversions);
						fails++;
					end
					if (result_data.bad_value !== want.bad_value) begin
						$error("bad_value: expected %0d, actual %0d",
							want.bad_value, result_data.bad_value);
						fails++;
					end
				end
			end
			if (item_valid && item_ready) begin
				predict_inversions(item_data, want);
				pending_results = {pending_results, want};
			end
			n_fail <= fails;
			n_pending <= pending_results.size();
			n_checked <= checked;
			n_bad <= bad_seen;
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the inversion counter testbench: clock, reset, stimulus, receiver and verdict.
module tb_top import fic_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN       = 1024;
	localparam int HOLD_CYCLES   = 1500;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT   = 50000;
	localparam int PHASE_ITEMS   = 34;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;
	int               tx_pct = 0;
	int               rx_pct = 0;
	int               hold_token = 0;
	int               n_settings = 0;
	int               n_fail;
	int               n_pending;
	int               n_checked;
	int               n_bad;

	fic_stream_if #(.T(fic_item_t))   item_if ();
	fic_stream_if #(.T(fic_result_t)) result_if ();

	fenwick_inversion_counter_top #(.MAX_LEN(MAX_LEN)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (item_if),
		.results   (result_if)
	);

	fic_inversion_checker #(.MAX_LEN(MAX_LEN)) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_if.valid),
		.item_ready   (item_if.ready),
		.item_data    (item_if.data),
		.result_valid (result_if.valid),
		.result_ready (result_if.ready),
		.result_data  (result_if.data),
		.n_fail       (n_fail),
		.n_pending    (n_pending),
		.n_checked    (n_checked),
		.n_bad        (n_bad)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off whenever the stimulus bumps hold_token.
	initial begin : rx_drive
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				result_if.ready <= 1'b0;
			end else if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
				result_if.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(99) >= rx_pct);
			end
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				tx_pct = 0;
				rx_pct <= 0;
			end
			IDLE_SEND: begin
				tx_pct = 79;
				rx_pct <= 0;
			end
			IDLE_RECV: begin
				tx_pct = 0;
				rx_pct <= 79;
			end
			default: begin
				tx_pct = 15;
				rx_pct <= 15;
			end
		endcase
	endtask

	// Offers one item and returns at the edge of its transfer, with valid still high.
	task automatic send_item(input logic [VALUE_W-1:0] v, input logic f);
		while (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.data <= '{value: v, first_item: f};
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		int guard;
		item_if.valid <= 1'b0;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (n_pending != 0 && guard < DRAIN_LIMIT);
		// The update walk may still run after the last result has left.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_len(input logic [LEN_W-1:0] len);
		cfg_wdata <= len;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Sequences of random length with random content; some start without the new-sequence
	// flag, some carry it midway, and a share of the values are out of range.
	task automatic random_phase(input logic [LEN_W-1:0] len, input idle_mode_t mode,
		input bit pressure);
		int               left;
		int               lim;
		int               r;
		int               n;
		logic [VALUE_W-1:0] v;
		logic             f;
		wait_drained();
		write_len(len);
		set_idling(mode);
		if (pressure) hold_token <= hold_token + 1;
		lim = (int'(len) > MAX_LEN) ? MAX_LEN : int'(len);
		left = 0;
		for (n = 0; n < PHASE_ITEMS; n++) begin
			if (left == 0) begin
				left = $urandom_range(40, 1);
				f = ($urandom_range(9) != 0);
			end else begin
				f = ($urandom_range(99) == 0);
			end
			left--;
			r = $urandom_range(99);
			if (lim == 0 || r < 8) v = VALUE_W'($urandom_range(MAX_LEN - 1));
			else if (r < 16 && lim < MAX_LEN) v = VALUE_W'($urandom_range(MAX_LEN - 1, lim));
			else v = VALUE_W'($urandom_range(lim - 1));
			send_item(v, f);
		end
	endtask

	initial begin : stimulus
		int i;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		item_if.valid <= 1'b0;
		item_if.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Default length; the tree starts clear even without the new-sequence flag.
		set_idling(IDLE_NONE);
		send_item(10'd512, 1'b0);
		send_item(10'd1023, 1'b0);
		send_item(10'd0, 1'b0);
		send_item(10'd1023, 1'b0);
		send_item(10'd600, 1'b0);
		send_item(10'd1023, 1'b1);
		send_item(10'd0, 1'b0);

		// Short length: out-of-range values, one of them also starting a new sequence.
		wait_drained();
		write_len(11'd5);
		send_item(10'd4, 1'b1);
		send_item(10'd5, 1'b0);
		send_item(10'd1023, 1'b1);
		send_item(10'd3, 1'b0);
		send_item(10'd4, 1'b0);
		send_item(10'd0, 1'b0);

		// A length of zero rejects everything.
		wait_drained();
		write_len(11'd0);
		send_item(10'd0, 1'b0);
		send_item(10'd1023, 1'b1);

		// A length above the tree size is capped at the tree size.
		wait_drained();
		write_len(11'd2047);
		send_item(10'd1023, 1'b1);
		send_item(10'd0, 1'b0);

		wait_drained();
		write_len(11'd1);
		send_item(10'd0, 1'b1);
		send_item(10'd1, 1'b0);
		send_item(10'd0, 1'b0);

		// Changing the length inside a sequence must not disturb the counts.
		wait_drained();
		write_len(11'd1024);
		send_item(10'd900, 1'b1);
		send_item(10'd800, 1'b0);
		wait_drained();
		write_len(11'd600);
		send_item(10'd100, 1'b0);
		send_item(10'd700, 1'b0);
		wait_drained();
		write_len(11'd1024);
		send_item(10'd850, 1'b0);

		// One long sequence: many large values, then many zeros, so the counts in the
		// nodes and the per-item count grow well past a handful.
		for (i = 0; i < 150; i++) send_item(10'd1023, i == 0);
		for (i = 0; i < 100; i++) send_item(10'd0, 1'b0);

		random_phase(11'd1024, IDLE_NONE, 1'b1);
		random_phase(11'd2047, IDLE_SEND, 1'b0);
		random_phase(11'd1, IDLE_RECV, 1'b0);
		random_phase(11'd16, IDLE_BOTH, 1'b0);
		random_phase(LEN_W'($urandom_range(1023, 2)), IDLE_NONE, 1'b1);
		random_phase(11'd1024, IDLE_SEND, 1'b0);
		random_phase(LEN_W'($urandom_range(2047, 1)), IDLE_RECV, 1'b0);
		random_phase(11'd300, IDLE_BOTH, 1'b0);

		wait_drained();
		$display("Checked %0d results, %0d of them out-of-range values, under %0d length settings.",
			n_checked, n_bad, n_settings + 1);
		$display("Phases ran with no idling, sender gaps, receiver stalls, both, and long holds.");
		if (n_pending != 0) $error("%0d expected results never arrived", n_pending);
		if (n_fail == 0 && n_pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
